// ===== rtl/rvsc_pkg.sv =====
`timescale 1ns / 1ps

package rvsc_pkg;

  // Data memory depth in words; kept to a power of two so the word index is a mask
  localparam int DMEM_WORDS = 32;
  localparam int DMEM_AW    = $clog2(DMEM_WORDS);
  localparam logic [29:0] DMEM_MASK = 30'(DMEM_WORDS - 1);

  // Opcodes of the supported subset
  localparam logic [6:0] OP_RTYPE = 7'h33;
  localparam logic [6:0] OP_ADDI  = 7'h13;
  localparam logic [6:0] OP_LOAD  = 7'h03;
  localparam logic [6:0] OP_STORE = 7'h23;
  localparam logic [6:0] OP_BEQ   = 7'h63;

  // funct7 code that turns add into sub
  localparam logic [6:0] FUNCT7_SUB = 7'h20;

  // Register file write port
  typedef struct packed {
    logic        en;
    logic [4:0]  addr;
    logic [31:0] data;
  } rf_wr_t;

  // Data memory write port
  typedef struct packed {
    logic               en;
    logic [DMEM_AW-1:0] addr;
    logic [31:0]        data;
  } dm_wr_t;

  // Everything one instruction produces
  typedef struct packed {
    logic [31:0] next_pc;
    logic        reg_written;
    logic [4:0]  dest_reg;
    logic [31:0] write_value;
    logic        mem_stored;
    logic [4:0]  mem_word_index;
    logic [31:0] store_value;
    logic        branch_taken;
  } exec_res_t;

endpackage

// ===== rtl/rvsc_regfile.sv =====
`timescale 1ns / 1ps

module rvsc_regfile (
  input  logic            clk,
  input  logic            rst,
  input  logic            rd_en,
  input  logic [4:0]      raddr1,
  input  logic [4:0]      raddr2,
  input  rvsc_pkg::rf_wr_t wr,
  output logic [31:0]     rdata1,
  output logic [31:0]     rdata2
);

  logic [31:0] regs [32];
  logic [31:0] vld;
  logic        wr_live;

  // x0 is never written, so its valid bit stays low and it reads zero
  assign wr_live = wr.en && (wr.addr != 5'd0);

  // Valid bits: reset clears all, a write sets one
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_live) begin
      vld[wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_live) begin
      regs[wr.addr] <= wr.data;
    end
  end

  // Registered reads, with bypass of a write landing on the same edge
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_live && (wr.addr == raddr1)) begin
        rdata1 <= wr.data;
      end else begin
        rdata1 <= vld[raddr1] ? regs[raddr1] : 32'd0;
      end
      if (wr_live && (wr.addr == raddr2)) begin
        rdata2 <= wr.data;
      end else begin
        rdata2 <= vld[raddr2] ? regs[raddr2] : 32'd0;
      end
    end
  end

endmodule

// ===== rtl/rvsc_dmem.sv =====
`timescale 1ns / 1ps

module rvsc_dmem (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [rvsc_pkg::DMEM_AW-1:0]  raddr,
  input  rvsc_pkg::dm_wr_t              wr,
  output logic [31:0]                   rdata
);

  logic [31:0]                   mem [rvsc_pkg::DMEM_WORDS];
  logic [rvsc_pkg::DMEM_WORDS-1:0] vld;

  // Unwritten words read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr.en) begin
      vld[wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  assign rdata = vld[raddr] ? mem[raddr] : 32'd0;

endmodule

// ===== rtl/rvsc_exec.sv =====
`timescale 1ns / 1ps

module rvsc_exec (
  input  logic [31:0]                   instruction,
  input  logic [31:0]                   pc,
  input  logic [31:0]                   rs1_val,
  input  logic [31:0]                   rs2_val,
  input  logic [31:0]                   dmem_rdata,
  output logic [rvsc_pkg::DMEM_AW-1:0]  dmem_addr,
  output rvsc_pkg::exec_res_t           res
);

  logic [6:0]  opc;
  logic [4:0]  rd;
  logic [6:0]  funct7;
  logic [31:0] imm_i;
  logic [31:0] imm_s;
  logic [31:0] imm_b;
  logic [31:0] pc_plus4;
  logic [31:0] addr;
  logic [29:0] widx;
  logic        wr;
  logic [31:0] wval;

  // Field decode and immediates
  assign opc    = instruction[6:0];
  assign rd     = instruction[11:7];
  assign funct7 = instruction[31:25];
  assign imm_i  = {{20{instruction[31]}}, instruction[31:20]};
  assign imm_s  = {{20{instruction[31]}}, instruction[31:25], instruction[11:7]};
  assign imm_b  = {{19{instruction[31]}}, instruction[31], instruction[7],
                   instruction[30:25], instruction[11:8], 1'b0};
  assign pc_plus4 = pc + 32'd4;

  // Byte address for lw or sw, then word index wrapped to the memory depth
  assign addr      = rs1_val + ((opc == rvsc_pkg::OP_STORE) ? imm_s : imm_i);
  assign widx      = addr[31:2] & rvsc_pkg::DMEM_MASK;
  assign dmem_addr = widx[rvsc_pkg::DMEM_AW-1:0];

  always_comb begin
    res         = '0;
    res.next_pc = pc_plus4;
    wr          = 1'b0;
    wval        = 32'd0;
    case (opc)
      rvsc_pkg::OP_RTYPE: begin
        wr   = 1'b1;
        wval = (funct7 == rvsc_pkg::FUNCT7_SUB) ? (rs1_val - rs2_val)
                                                : (rs1_val + rs2_val);
      end
      rvsc_pkg::OP_ADDI: begin
        wr   = 1'b1;
        wval = rs1_val + imm_i;
      end
      rvsc_pkg::OP_LOAD: begin
        wr                 = 1'b1;
        wval               = dmem_rdata;
        res.mem_word_index = widx[4:0];
      end
      rvsc_pkg::OP_STORE: begin
        res.mem_stored     = 1'b1;
        res.mem_word_index = widx[4:0];
        res.store_value    = rs2_val;
      end
      rvsc_pkg::OP_BEQ: begin
        if (rs1_val == rs2_val) begin
          res.branch_taken = 1'b1;
          res.next_pc      = pc + imm_b;
        end
      end
      default: begin
      end
    endcase
    // Writes to x0 are dropped and reported as no write
    if (wr && (rd != 5'd0)) begin
      res.reg_written = 1'b1;
      res.dest_reg    = rd;
      res.write_value = wval;
    end
  end

endmodule

// ===== rtl/rv32_subset_single_cycle_core.sv =====
`timescale 1ns / 1ps
// An accepted instruction sits in the instruction register, then its result word in
// the result register; one instruction per cycle unless out_ready stalls the output.
// Register read is registered on accept; ALU, data memory and write-back follow it.
// Reset (rst, synchronous): PC to zero, register file and data memory read as zero
// through per-entry valid bits, both pipeline stages emptied; no clearing pass.
module rv32_subset_single_cycle_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        instruction,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        next_pc,
  output logic               reg_written,
  output logic [4:0]         dest_reg,
  output logic signed [31:0] write_value,
  output logic               mem_stored,
  output logic [4:0]         mem_word_index,
  output logic signed [31:0] store_value,
  output logic               branch_taken
);

  logic                         s1_valid;
  logic [31:0]                  s1_instr;
  logic [31:0]                  pc;
  logic                         advance;
  logic                         accept;
  logic [31:0]                  rs1_val;
  logic [31:0]                  rs2_val;
  logic [31:0]                  dmem_rdata;
  logic [rvsc_pkg::DMEM_AW-1:0] dmem_addr;
  rvsc_pkg::exec_res_t          res;
  rvsc_pkg::rf_wr_t             rf_wr;
  rvsc_pkg::dm_wr_t             dm_wr;

  // Handshake: the instruction stage moves on whenever the result register is free
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;
  assign accept   = in_valid && in_ready;

  // Instruction stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_instr <= instruction;
    end
  end

  // Program counter commits with the instruction
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= 32'd0;
    end else if (advance) begin
      pc <= res.next_pc;
    end
  end

  // State writes happen as the instruction leaves the stage
  assign rf_wr.en   = advance && res.reg_written;
  assign rf_wr.addr = res.dest_reg;
  assign rf_wr.data = res.write_value;

  assign dm_wr.en   = advance && res.mem_stored;
  assign dm_wr.addr = dmem_addr;
  assign dm_wr.data = res.store_value;

  rvsc_regfile u_regfile (
    .clk    (clk),
    .rst    (rst),
    .rd_en  (accept),
    .raddr1 (instruction[19:15]),
    .raddr2 (instruction[24:20]),
    .wr     (rf_wr),
    .rdata1 (rs1_val),
    .rdata2 (rs2_val)
  );

  rvsc_exec u_exec (
    .instruction (s1_instr),
    .pc          (pc),
    .rs1_val     (rs1_val),
    .rs2_val     (rs2_val),
    .dmem_rdata  (dmem_rdata),
    .dmem_addr   (dmem_addr),
    .res         (res)
  );

  rvsc_dmem u_dmem (
    .clk   (clk),
    .rst   (rst),
    .raddr (dmem_addr),
    .wr    (dm_wr),
    .rdata (dmem_rdata)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      next_pc        <= res.next_pc;
      reg_written    <= res.reg_written;
      dest_reg       <= res.dest_reg;
      write_value    <= res.write_value;
      mem_stored     <= res.mem_stored;
      mem_word_index <= res.mem_word_index;
      store_value    <= res.store_value;
      branch_taken   <= res.branch_taken;
    end
  end

endmodule

// ===== rtl/rvsc_checker.sv =====
`timescale 1ns / 1ps

module rvsc_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic [31:0]        next_pc,
  input logic               reg_written,
  input logic [4:0]         dest_reg,
  input logic signed [31:0] write_value,
  input logic               mem_stored,
  input logic               branch_taken
);

  // A word with no write-back carries zero destination and value
  a_no_wb_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !reg_written) |-> (dest_reg == 5'd0 && write_value == 32'sd0))
    else $error("write-back fields set without a register write");

  // x0 is never reported as written
  a_no_x0: assert property (@(posedge clk) disable iff (rst)
    (out_valid && reg_written) |-> (dest_reg != 5'd0))
    else $error("register write reported for x0");

  // Store, write-back and taken branch exclude one another
  a_one_effect: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot0({reg_written, mem_stored, branch_taken}))
    else $error("more than one effect in one result word");

  // A stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(next_pc) && $stable(write_value)))
    else $error("stalled result word changed");

endmodule

bind rv32_subset_single_cycle_core rvsc_checker u_rvsc_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .next_pc      (next_pc),
  .reg_written  (reg_written),
  .dest_reg     (dest_reg),
  .write_value  (write_value),
  .mem_stored   (mem_stored),
  .branch_taken (branch_taken)
);

// ===== verif/rv32_subset_single_cycle_core_tb.sv =====
`timescale 1ns / 1ps

module rv32_subset_single_cycle_core_tb;

  // Opcode outside the subset, used to check that it only advances the PC
  localparam logic [6:0] OP_LUI = 7'h37;

  logic        clk         = 1'b0;
  logic        rst         = 1'b1;
  logic        in_valid    = 1'b0;
  logic [31:0] instruction = '0;
  logic        out_ready   = 1'b0;

  logic               in_ready;
  logic               out_valid;
  logic [31:0]        next_pc;
  logic               reg_written;
  logic [4:0]         dest_reg;
  logic signed [31:0] write_value;
  logic               mem_stored;
  logic [4:0]         mem_word_index;
  logic signed [31:0] store_value;
  logic               branch_taken;

  rv32_subset_single_cycle_core u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .instruction    (instruction),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .next_pc        (next_pc),
    .reg_written    (reg_written),
    .dest_reg       (dest_reg),
    .write_value    (write_value),
    .mem_stored     (mem_stored),
    .mem_word_index (mem_word_index),
    .store_value    (store_value),
    .branch_taken   (branch_taken)
  );

  // Architectural state as the core should hold it
  logic [31:0] arch_pc = '0;
  logic [31:0] arch_regs [32] = '{default: '0};
  logic [31:0] arch_dmem [rvsc_pkg::DMEM_WORDS] = '{default: '0};

  logic [31:0]         instr_queue [$];
  rvsc_pkg::exec_res_t expected_results [$];

  int n_fail    = 0;
  int in_gap    = 0;
  int out_stall = 0;
  int in_calm   = 0;
  int out_calm  = 0;

  // Clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Reset, once
  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
  end

  // Watchdog
  initial begin
    #3_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Wait length for one word, 0 to 11, with occasional stretches of no idling
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 29) == 0) calm = $urandom_range(10, 40);
    return $urandom_range(0, 11);
  endfunction

  // Execute one instruction on the architectural state
  function automatic rvsc_pkg::exec_res_t execute_instr(logic [31:0] ins);
    rvsc_pkg::exec_res_t r;
    logic [6:0]  opc;
    logic [4:0]  rd;
    logic [31:0] a, b, addr, wval;
    logic        wr;
    int unsigned widx;
    opc  = ins[6:0];
    rd   = ins[11:7];
    a    = arch_regs[ins[19:15]];
    b    = arch_regs[ins[24:20]];
    r    = '0;
    r.next_pc = arch_pc + 32'd4;
    wr   = 1'b0;
    wval = '0;
    widx = 0;
    case (opc)
      rvsc_pkg::OP_RTYPE: begin
        wr   = 1'b1;
        wval = (ins[31:25] == rvsc_pkg::FUNCT7_SUB) ? a - b : a + b;
      end
      rvsc_pkg::OP_ADDI: begin
        wr   = 1'b1;
        wval = a + {{20{ins[31]}}, ins[31:20]};
      end
      rvsc_pkg::OP_LOAD: begin
        addr = a + {{20{ins[31]}}, ins[31:20]};
        widx = (addr >> 2) % rvsc_pkg::DMEM_WORDS;
        wr   = 1'b1;
        wval = arch_dmem[widx];
      end
      rvsc_pkg::OP_STORE: begin
        addr = a + {{20{ins[31]}}, ins[31:25], ins[11:7]};
        widx = (addr >> 2) % rvsc_pkg::DMEM_WORDS;
        arch_dmem[widx] = b;
        r.mem_stored  = 1'b1;
        r.store_value = b;
      end
      rvsc_pkg::OP_BEQ: begin
        if (a == b) begin
          r.branch_taken = 1'b1;
          r.next_pc = arch_pc + {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
        end
      end
      default: ;
    endcase
    // x0 swallows the write-back
    if (wr && rd != 5'd0) begin
      arch_regs[rd]  = wval;
      r.reg_written  = 1'b1;
      r.dest_reg     = rd;
      r.write_value  = wval;
    end
    r.mem_word_index = 5'(widx);
    arch_pc = r.next_pc;
    return r;
  endfunction

  // Instruction encoders
  function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, rs1,
                                        logic [2:0] f3, logic [4:0] rd);
    return {f7, rs2, rs1, f3, rd, rvsc_pkg::OP_RTYPE};
  endfunction

  function automatic logic [31:0] enc_i(logic [6:0] opc, logic [11:0] imm, logic [4:0] rs1,
                                        logic [2:0] f3, logic [4:0] rd);
    return {imm, rs1, f3, rd, opc};
  endfunction

  function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs2, rs1,
                                        logic [2:0] f3);
    return {imm[11:5], rs2, rs1, f3, imm[4:0], rvsc_pkg::OP_STORE};
  endfunction

  function automatic logic [31:0] enc_b(logic [12:0] imm, logic [4:0] rs2, rs1,
                                        logic [2:0] f3);
    return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], rvsc_pkg::OP_BEQ};
  endfunction

  // Favour a few low registers so operands collide and memory is reused
  function automatic logic [4:0] pick_reg();
    if ($urandom_range(0, 2) != 0) return 5'($urandom_range(0, 7));
    return 5'($urandom);
  endfunction

  // Mostly well-formed subset instructions, some noise
  function automatic logic [31:0] random_instr();
    int unsigned sel;
    logic [4:0]  rs1, rs2, rd;
    logic [11:0] imm;
    logic [6:0]  f7;
    logic [2:0]  f3;
    logic [31:0] raw;
    sel = $urandom_range(0, 99);
    rs1 = pick_reg();
    rs2 = ($urandom_range(0, 4) == 0) ? rs1 : pick_reg();
    rd  = pick_reg();
    f3  = 3'($urandom);
    raw = $urandom;
    imm = $urandom_range(0, 1) ? 12'($urandom) : 12'($urandom_range(0, 63) * 4);
    case ($urandom_range(0, 19))
      0, 1, 2:        f7 = 7'($urandom);
      3, 4, 5, 6, 7,
      8, 9:           f7 = 7'h00;
      default:        f7 = rvsc_pkg::FUNCT7_SUB;
    endcase
    if (sel < 25) return enc_i(rvsc_pkg::OP_ADDI, imm, rs1, f3, rd);
    if (sel < 45) return enc_r(f7, rs2, rs1, f3, rd);
    if (sel < 60) return enc_i(rvsc_pkg::OP_LOAD, imm, rs1, f3, rd);
    if (sel < 75) return enc_s(imm, rs2, rs1, f3);
    if (sel < 88) return enc_b(13'($urandom), rs2, rs1, f3);
    if (sel < 95) return raw;
    return {raw[31:7], 7'($urandom)};
  endfunction

  // Driver: one instruction word at a time from the pending queue
  always @(posedge clk) begin : instr_driver
    int g;
    if (rst) begin
      in_valid <= 1'b0;
      in_gap   <= 0;
    end else begin
      if (in_valid && in_ready)
        expected_results.push_back(execute_instr(instruction));
      if (!in_valid || in_ready) begin
        if (in_gap != 0) begin
          in_valid <= 1'b0;
          in_gap   <= in_gap - 1;
        end else if (instr_queue.size() != 0) begin
          g = draw_wait(in_calm);
          in_valid    <= 1'b1;
          instruction <= instr_queue.pop_front();
          in_gap      <= g;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s: expected %h, actual %h", name, exp_val, act_val);
      n_fail++;
    end
  endtask

  // Monitor: compare each result word with the oldest expectation
  always @(posedge clk) begin : result_monitor
    rvsc_pkg::exec_res_t exp_res;
    int        s;
    if (rst) begin
      out_ready <= 1'b0;
      out_stall <= 0;
    end else if (out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("result word with no instruction outstanding");
        n_fail++;
      end else begin
        exp_res = expected_results.pop_front();
        check_field("next_pc",        exp_res.next_pc,        next_pc);
        check_field("reg_written",    32'(exp_res.reg_written),    32'(reg_written));
        check_field("dest_reg",       32'(exp_res.dest_reg),       32'(dest_reg));
        check_field("write_value",    exp_res.write_value,    write_value);
        check_field("mem_stored",     32'(exp_res.mem_stored),     32'(mem_stored));
        check_field("mem_word_index", 32'(exp_res.mem_word_index), 32'(mem_word_index));
        check_field("store_value",    exp_res.store_value,    store_value);
        check_field("branch_taken",   32'(exp_res.branch_taken),   32'(branch_taken));
      end
      s = draw_wait(out_calm);
      out_stall <= s;
      out_ready <= (s == 0);
    end else if (out_stall != 0) begin
      out_stall <= out_stall - 1;
      out_ready <= (out_stall == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Stimulus and end of run
  initial begin
    // immediate extremes
    instr_queue.push_back(enc_i(rvsc_pkg::OP_ADDI, 12'h7FF, 5'd0, 3'd0, 5'd1));
    instr_queue.push_back(enc_i(rvsc_pkg::OP_ADDI, 12'h800, 5'd0, 3'd5, 5'd2));
    instr_queue.push_back(enc_i(rvsc_pkg::OP_ADDI, 12'hFFF, 5'd0, 3'd0, 5'd3));
    // add, sub, and a non-sub funct7 with funct3 set
    instr_queue.push_back(enc_r(7'h00, 5'd2, 5'd1, 3'd0, 5'd4));
    instr_queue.push_back(enc_r(rvsc_pkg::FUNCT7_SUB, 5'd1, 5'd2, 3'd7, 5'd5));
    instr_queue.push_back(enc_r(7'h7F, 5'd3, 5'd3, 3'd2, 5'd6));
    // writes to x0 are dropped
    instr_queue.push_back(enc_r(7'h00, 5'd1, 5'd1, 3'd0, 5'd0));
    instr_queue.push_back(enc_i(rvsc_pkg::OP_ADDI, 12'd5, 5'd1, 3'd0, 5'd0));
    // stores: first word, last word, wrap past the depth
    instr_queue.push_back(enc_s(12'd0, 5'd3, 5'd0, 3'd0));
    instr_queue.push_back(enc_s(12'd124, 5'd1, 5'd0, 3'd2));
    instr_queue.push_back(enc_s(12'd128, 5'd2, 5'd0, 3'd0));
    // loads, including a negative address that wraps to the top word
    instr_queue.push_back(enc_i(rvsc_pkg::OP_LOAD, 12'd0, 5'd0, 3'd2, 5'd7));
    instr_queue.push_back(enc_i(rvsc_pkg::OP_LOAD, 12'hFFC, 5'd0, 3'd2, 5'd8));
    // unaligned address from a negative base: low bits dropped
    instr_queue.push_back(enc_s(12'd3, 5'd1, 5'd3, 3'd0));
    instr_queue.push_back(enc_i(rvsc_pkg::OP_LOAD, 12'd5, 5'd0, 3'd0, 5'd9));
    instr_queue.push_back(enc_i(rvsc_pkg::OP_LOAD, 12'd0, 5'd0, 3'd0, 5'd0));
    instr_queue.push_back(enc_r(rvsc_pkg::FUNCT7_SUB, 5'd2, 5'd0, 3'd0, 5'd10));
    // branches: most negative offset wraps the PC, not taken, most positive, odd halfword
    instr_queue.push_back(enc_b(13'h1000, 5'd0, 5'd0, 3'd0));
    instr_queue.push_back(enc_b(13'd8, 5'd2, 5'd1, 3'd0));
    instr_queue.push_back(enc_b(13'h0FFE, 5'd3, 5'd3, 3'd1));
    instr_queue.push_back(enc_b(13'd2, 5'd7, 5'd2, 3'd7));
    // opcodes outside the subset
    instr_queue.push_back(32'h0000_0000);
    instr_queue.push_back(32'hFFFF_FFFF);
    instr_queue.push_back(enc_i(OP_LUI, 12'hABC, 5'd1, 3'd0, 5'd12));

    repeat (700) instr_queue.push_back(random_instr());

    // drain, then allow the result latency to pass for any stray word
    @(posedge clk);
    while (instr_queue.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
    if (n_fail == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
